// ===== hw/rtl/fibonacci_mod_m_top_macros.svh =====
// Assertion macros for the Fibonacci residue block.
`ifndef FIBONACCI_MOD_M_TOP_MACROS_SVH
`define FIBONACCI_MOD_M_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FMM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FMM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FMM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/fmm_pkg.sv =====
// Shared types and constants for the Fibonacci residue block.
`timescale 1ns / 1ps
package fmm_pkg;
    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    // Datapath commands
    localparam logic [2:0] CMD_IDLE  = 3'd0;
    localparam logic [2:0] CMD_LOAD  = 3'd1;
    localparam logic [2:0] CMD_PREP  = 3'd2;
    localparam logic [2:0] CMD_MSTART = 3'd3;
    localparam logic [2:0] CMD_MSTEP = 3'd4;
    localparam logic [2:0] CMD_MSAVE = 3'd5;
    localparam logic [2:0] CMD_COMB  = 3'd6;

    // Multiplier operand selects: F(k)*t, F(k)^2, F(k+1)^2
    localparam logic [1:0] MSEL_FK_T  = 2'd0;
    localparam logic [1:0] MSEL_FK_SQ = 2'd1;
    localparam logic [1:0] MSEL_FK1_SQ = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] msel;
    } t_cmd;

    typedef struct packed {
        logic mul_last;
        logic bit_last;
    } t_stat;
endpackage

// ===== hw/rtl/fmm_datapath.sv =====
// Datapath: operand registers and a shared bit-serial modular multiplier.
`timescale 1ns / 1ps
module fmm_datapath import fmm_pkg::*; (
    input  logic                 i_clk,
    input  logic [WORD_BITS-1:0] i_fib_index,
    input  logic [WORD_BITS-1:0] i_modulus,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic [WORD_BITS-1:0] o_fk
);
    logic [WORD_BITS-1:0] r_n, r_m, r_fk, r_fk1, r_t, r_p0, r_p1, r_p2;
    logic [WORD_BITS-1:0] r_x, r_y, r_acc;
    logic [CNT_BITS-1:0]  r_mcnt, r_bcnt;
    logic [WORD_BITS-1:0] n_dbl, n_acc, v_f2k, v_f2k1, v_two, v_t;

    // Modular add and subtract for operands below the modulus
    function automatic logic [WORD_BITS-1:0] add_mod(
        input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
        input logic [WORD_BITS-1:0] md);
        logic [WORD_BITS-1:0] room;
        room = md - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

    function automatic logic [WORD_BITS-1:0] sub_mod(
        input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
        input logic [WORD_BITS-1:0] md);
        return (a >= b) ? (a - b) : (a + (md - b));
    endfunction

    // One double-and-add step of the multiplier
    always_comb begin
        n_dbl = add_mod(r_acc, r_acc, r_m);
        n_acc = r_y[WORD_BITS-1] ? add_mod(n_dbl, r_x, r_m) : n_dbl;
    end

    // Combine products into the next ladder pair
    always_comb begin
        v_f2k  = r_p0;
        v_f2k1 = add_mod(r_p1, r_p2, r_m);
        v_two  = add_mod(r_fk1, r_fk1, r_m);
        v_t    = sub_mod(v_two, r_fk, r_m);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_LOAD: begin
                r_n    <= i_fib_index;
                r_m    <= i_modulus;
                r_fk   <= '0;
                r_fk1  <= (i_modulus == {{(WORD_BITS-1){1'b0}}, 1'b1}) ? '0
                          : {{(WORD_BITS-1){1'b0}}, 1'b1};
                r_bcnt <= CNT_BITS'(WORD_BITS - 1);
            end
            CMD_PREP: r_t <= v_t;
            CMD_MSTART: begin
                r_acc  <= '0;
                r_mcnt <= CNT_BITS'(WORD_BITS - 1);
                case (i_cmd.msel)
                    MSEL_FK_T:  begin r_x <= r_fk;  r_y <= r_t;   end
                    MSEL_FK_SQ: begin r_x <= r_fk;  r_y <= r_fk;  end
                    default:    begin r_x <= r_fk1; r_y <= r_fk1; end
                endcase
            end
            CMD_MSTEP: begin
                r_acc  <= n_acc;
                r_y    <= r_y << 1;
                r_mcnt <= r_mcnt - 1'b1;
            end
            CMD_MSAVE: begin
                case (i_cmd.msel)
                    MSEL_FK_T:  r_p0 <= r_acc;
                    MSEL_FK_SQ: r_p1 <= r_acc;
                    default:    r_p2 <= r_acc;
                endcase
            end
            CMD_COMB: begin
                if (r_n[WORD_BITS-1]) begin
                    r_fk  <= v_f2k1;
                    r_fk1 <= add_mod(v_f2k, v_f2k1, r_m);
                end else begin
                    r_fk  <= v_f2k;
                    r_fk1 <= v_f2k1;
                end
                r_n    <= r_n << 1;
                r_bcnt <= r_bcnt - 1'b1;
            end
            default: ;
        endcase
    end

    assign o_stat.mul_last = (r_mcnt == '0);
    assign o_stat.bit_last = (r_bcnt == '0);
    assign o_fk = r_fk;
endmodule

// ===== hw/rtl/fmm_ctrl.sv =====
// Controller: sequences ladder steps and handles the handshake.
`timescale 1ns / 1ps
module fmm_ctrl import fmm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_zero_mod,
    input  t_stat                i_stat,
    output t_cmd                 o_cmd,
    output logic                 o_done,
    output logic                 o_bad,
    input  logic                 i_out_free
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MST  = 3'd2;
    localparam logic [2:0] S_MRUN = 3'd3;
    localparam logic [2:0] S_MSAV = 3'd4;
    localparam logic [2:0] S_COMB = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_msel, n_msel;
    logic       r_bad, n_bad;
    logic       v_take;

    assign o_stall = (r_state != S_IDLE);
    assign v_take  = i_valid && (r_state == S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        n_msel     = r_msel;
        n_bad      = r_bad;
        o_cmd.op   = CMD_IDLE;
        o_cmd.msel = r_msel;
        o_done     = 1'b0;
        case (r_state)
            S_IDLE: if (v_take) begin
                o_cmd.op = CMD_LOAD;
                n_bad    = i_zero_mod;
                n_state  = i_zero_mod ? S_DONE : S_PREP;
            end
            S_PREP: begin
                o_cmd.op = CMD_PREP;
                n_msel   = MSEL_FK_T;
                n_state  = S_MST;
            end
            S_MST: begin
                o_cmd.op = CMD_MSTART;
                n_state  = S_MRUN;
            end
            S_MRUN: begin
                o_cmd.op = CMD_MSTEP;
                if (i_stat.mul_last) n_state = S_MSAV;
            end
            S_MSAV: begin
                o_cmd.op = CMD_MSAVE;
                if (r_msel == MSEL_FK1_SQ) begin
                    n_state = S_COMB;
                end else begin
                    n_msel  = r_msel + 2'd1;
                    n_state = S_MST;
                end
            end
            S_COMB: begin
                o_cmd.op = CMD_COMB;
                n_state  = i_stat.bit_last ? S_DONE : S_PREP;
            end
            S_DONE: if (i_out_free) begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_msel  <= MSEL_FK_T;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_msel  <= n_msel;
            r_bad   <= n_bad;
        end
    end

    assign o_bad = r_bad;
endmodule

// ===== hw/rtl/fibonacci_mod_m_top.sv =====
// Each index bit runs PREP, then three double-and-add multiplications (MSTART, MSTEP
// repeated until the count ends, MSAVE) on one shared unit, then COMB.
// Zero modulus goes from the load straight to the done state, with the error flag set.
// A new input is taken only after the last result has moved into the output register.
// Reset (synchronous, active low) clears the controller and output valid.
`timescale 1ns / 1ps
`include "fibonacci_mod_m_top_macros.svh"
module fibonacci_mod_m_top import fmm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_BITS-1:0] i_fib_index,
    input  logic [WORD_BITS-1:0] i_modulus,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_BITS-1:0] o_fib_residue,
    output logic                 o_bad_modulus
);
    t_cmd                 w_cmd;
    t_stat                w_stat;
    logic [WORD_BITS-1:0] w_fk;
    logic                 w_done, w_bad, w_free;
    logic                 r_valid;
    logic [WORD_BITS-1:0] r_res;
    logic                 r_badm;

    assign w_free = !r_valid || !i_stall;

    fmm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_zero_mod(i_modulus == '0), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_done(w_done), .o_bad(w_bad), .i_out_free(w_free)
    );

    fmm_datapath u_dp (
        .i_clk(i_clk), .i_fib_index(i_fib_index), .i_modulus(i_modulus),
        .i_cmd(w_cmd), .o_stat(w_stat), .o_fk(w_fk)
    );

    // Hold result until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_done) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_res  <= w_bad ? '0 : w_fk;
            r_badm <= w_bad;
        end
    end

    assign o_valid       = r_valid;
    assign o_fib_residue = r_res;
    assign o_bad_modulus = r_badm;

    `FMM_ASSERT_IMPL(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_modulus, o_fib_residue == '0)
    `FMM_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `FMM_ASSERT_IMPL(a_done_free, i_clk, i_rst_n, w_done, w_free)
endmodule

// ===== tb/fibonacci_mod_m_checker.sv =====
// Checker for the Fibonacci residue block: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module fibonacci_mod_m_checker import fmm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [WORD_BITS-1:0] i_fib_index,
    input  logic [WORD_BITS-1:0] i_modulus,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [WORD_BITS-1:0] i_fib_residue,
    input  logic                 i_bad_modulus,
    output int                   o_fail_count,
    output int                   o_pending
);
    typedef struct packed {
        logic [WORD_BITS-1:0] residue;
        logic                 bad;
    } t_residue_exp;

    t_residue_exp residue_q[$];

    // (x * y) mod m on a double-width product
    function automatic logic [WORD_BITS-1:0] mul_mod_m(
        input logic [WORD_BITS-1:0] x,
        input logic [WORD_BITS-1:0] y,
        input logic [WORD_BITS-1:0] m
    );
        logic [2*WORD_BITS-1:0] prod;
        prod = {{WORD_BITS{1'b0}}, x} * {{WORD_BITS{1'b0}}, y};
        return WORD_BITS'(prod % {{WORD_BITS{1'b0}}, m});
    endfunction

    // F(n) mod m by fast doubling from the top bit of n down
    function automatic t_residue_exp fib_residue_of(
        input logic [WORD_BITS-1:0] n,
        input logic [WORD_BITS-1:0] m
    );
        t_residue_exp         res;
        logic [WORD_BITS-1:0] fk, fk1, twice, f2k, f2k1;
        logic [WORD_BITS+1:0] wide;
        res = '0;
        if (m == '0) begin
            res.bad = 1'b1;
            return res;
        end
        fk  = '0;
        fk1 = (m == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            wide  = ({2'b0, fk1} * 2 + {2'b0, m} - {2'b0, fk}) % {2'b0, m};
            twice = wide[WORD_BITS-1:0];
            f2k   = mul_mod_m(fk, twice, m);
            wide  = ({2'b0, mul_mod_m(fk, fk, m)} + {2'b0, mul_mod_m(fk1, fk1, m)})
                    % {2'b0, m};
            f2k1  = wide[WORD_BITS-1:0];
            if (n[i]) begin
                fk   = f2k1;
                wide = ({2'b0, f2k} + {2'b0, f2k1}) % {2'b0, m};
                fk1  = wide[WORD_BITS-1:0];
            end else begin
                fk  = f2k;
                fk1 = f2k1;
            end
        end
        res.residue = fk;
        return res;
    endfunction

    assign o_pending = residue_q.size();

    // Predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_residue_exp want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                residue_q.push_back(fib_residue_of(i_fib_index, i_modulus));
            if (i_out_valid && !i_out_stall) begin
                if (residue_q.size() == 0) begin
                    $display("%0t: unexpected result residue=%h bad=%b", $time,
                             i_fib_residue, i_bad_modulus);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = residue_q.pop_front();
                    if (want.residue !== i_fib_residue || want.bad !== i_bad_modulus) begin
                        $display("%0t: mismatch residue exp=%h act=%h, bad exp=%b act=%b",
                                 $time, want.residue, i_fib_residue, want.bad,
                                 i_bad_modulus);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/fibonacci_mod_m_top_test.sv =====
// Top of the Fibonacci residue testbench: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module fibonacci_mod_m_top_test;
    import fmm_pkg::*;

    localparam int  RANDOM_ITEMS = 100;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [WORD_BITS-1:0] i_fib_index = '0;
    logic [WORD_BITS-1:0] i_modulus = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [WORD_BITS-1:0] o_fib_residue;
    logic                 o_bad_modulus;
    int                   fail_count;
    int                   pending;
    longint               cycle_count = 0;

    always #10 i_clk = ~i_clk;

    fibonacci_mod_m_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_fib_index   (i_fib_index),
        .i_modulus     (i_modulus),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_fib_residue (o_fib_residue),
        .o_bad_modulus (o_bad_modulus)
    );

    fibonacci_mod_m_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_fib_index   (i_fib_index),
        .i_modulus     (i_modulus),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_fib_residue (o_fib_residue),
        .i_bad_modulus (o_bad_modulus),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Present one index/modulus pair and hold it until the transfer, then maybe idle
    task automatic send_pair(input logic [WORD_BITS-1:0] n, input logic [WORD_BITS-1:0] m);
        int gap;
        i_valid     <= 1'b1;
        i_fib_index <= n;
        i_modulus   <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver stalls: runs of free flow broken by random stall bursts
    initial begin
        int run;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            i_stall <= 1'b0;
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 3000) : $urandom_range(1, 40);
            repeat (run) @(posedge i_clk);
            run = idle_len();
            if (run > 0) begin
                i_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
            end
        end
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [WORD_BITS-1:0] n, m;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero modulus, modulus one, tiny indexes, extremes of both fields
        send_pair('0, '0);
        send_pair('1, '0);
        send_pair(64'd12345, '0);
        send_pair(64'd0, 64'd1);
        send_pair('1, 64'd1);
        send_pair(64'd0, 64'd1000);
        send_pair(64'd1, 64'd1000);
        send_pair(64'd1, 64'd1);
        send_pair(64'd2, 64'd2);
        send_pair(64'd10, 64'd1000);
        send_pair(64'd90, '1);
        send_pair(64'd93, '1);
        send_pair('1, '1);
        send_pair('1, 64'h8000_0000_0000_0000);
        send_pair(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5);
        send_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_pair(64'd100, 64'd3);
        send_pair('1, 64'd2);

        // Hold off until the block has drained
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Random: full-width pairs, small moduli, and the odd zero modulus
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            n = rand_word();
            case ($urandom_range(0, 9))
                0:       m = '0;
                1, 2:    m = WORD_BITS'($urandom_range(1, 100));
                3:       m = rand_word() | 64'h8000_0000_0000_0000;
                default: m = rand_word();
            endcase
            if ($urandom_range(0, 7) == 0) n = WORD_BITS'($urandom_range(0, 200));
            send_pair(n, m);
        end
        i_valid <= 1'b0;

        // Drain, then let the latency run out
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== fibonacci_mod_m_top.f =====
+incdir+hw/rtl
hw/rtl/fmm_pkg.sv
hw/rtl/fmm_datapath.sv
hw/rtl/fmm_ctrl.sv
hw/rtl/fibonacci_mod_m_top.sv
tb/fibonacci_mod_m_checker.sv
tb/fibonacci_mod_m_top_test.sv
